[sv/bitmap_store_with_popcount_top_macros.svh]
// Assertion macros shared by the bitmap store with population count.
`ifndef BITMAP_STORE_WITH_POPCOUNT_TOP_MACROS_SVH
`define BITMAP_STORE_WITH_POPCOUNT_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BMS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/bms_pkg.sv]
// Shared types, constants and functions of the bitmap store with population count.
`default_nettype none
package bms_pkg;

  localparam int WORDS_DEFAULT = 1024;
  localparam int WORD_W        = 64;
  localparam int COUNT_W       = 17;
  localparam int POP_W         = 7;
  localparam int IN_TDATA_W    = 96;
  localparam int OUT_TDATA_W   = 24;
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;

  localparam logic [COUNT_W-1:0] ACTIVE_BITS_RESET = 17'h10000;
  localparam logic               REG_ACTIVE_BITS   = 1'b0;

  typedef enum logic [2:0] {
    OP_SET_BIT   = 3'd0,
    OP_CLEAR_BIT = 3'd1,
    OP_TEST_BIT  = 3'd2,
    OP_OR_WORD   = 3'd3,
    OP_AND_WORD  = 3'd4,
    OP_CLEAR_ALL = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MODIFY
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  // Pairwise adder tree, six levels deep.
  function automatic logic [POP_W-1:0] pop64(input logic [WORD_W-1:0] v);
    logic [1:0] p2  [32];
    logic [2:0] p4  [16];
    logic [3:0] p8  [8];
    logic [4:0] p16 [4];
    logic [5:0] p32 [2];
    for (int i = 0; i < 32; i++) begin
      p2[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    end
    for (int i = 0; i < 16; i++) begin
      p4[i] = {1'b0, p2[2*i]} + {1'b0, p2[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      p8[i] = {1'b0, p4[2*i]} + {1'b0, p4[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      p16[i] = {1'b0, p8[2*i]} + {1'b0, p8[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      p32[i] = {1'b0, p16[2*i]} + {1'b0, p16[2*i+1]};
    end
    return {1'b0, p32[0]} + {1'b0, p32[1]};
  endfunction

endpackage
`default_nettype wire

[sv/bms_regs.sv]
// Configuration register block holding the active bit count and the derived limit.
`default_nettype none
module bms_regs #(
  parameter int WORDS = bms_pkg::WORDS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bms_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [bms_pkg::PDATA_W-1:0]   pwdata,
  output logic      [bms_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  output logic      [bms_pkg::COUNT_W-1:0]   limit
);

  localparam longint CAP = longint'(WORDS) * bms_pkg::WORD_W;
  localparam logic [bms_pkg::COUNT_W-1:0] CAP_LIM =
    (CAP >= 131071) ? 17'h1FFFF : bms_pkg::COUNT_W'(CAP);

  logic [bms_pkg::COUNT_W-1:0] active_bits;
  logic                        hit;
  logic                        wr;
  logic [bms_pkg::COUNT_W-1:0] wval;

  assign pready = 1'b1;
  assign hit    = (paddr[2] == bms_pkg::REG_ACTIVE_BITS);
  assign wr     = psel && penable && pwrite && pready && hit;
  assign wval   = pwdata[bms_pkg::COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active_bits <= bms_pkg::ACTIVE_BITS_RESET;
      limit       <= (bms_pkg::ACTIVE_BITS_RESET < CAP_LIM) ?
                     bms_pkg::ACTIVE_BITS_RESET : CAP_LIM;
    end else if (wr) begin
      active_bits <= wval;
      limit       <= (wval < CAP_LIM) ? wval : CAP_LIM;
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = bms_pkg::PDATA_W'(active_bits);
    end
  end

endmodule
`default_nettype wire

[sv/bms_mem.sv]
// Word store: single-port-write, single-port-read memory with registered read data.
`default_nettype none
module bms_mem #(
  parameter int WORDS = bms_pkg::WORDS_DEFAULT,
  parameter int AW    = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  wire logic                        clk,
  input  wire bms_pkg::mem_ctl_t           ctl,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [bms_pkg::WORD_W-1:0]  wr_data,
  input  wire logic [AW-1:0]               rd_addr,
  output logic      [bms_pkg::WORD_W-1:0]  rd_data
);

  logic [bms_pkg::WORD_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[sv/bms_core.sv]
// Sequencer and read-modify-write datapath with the live set-bit count.
`default_nettype none
module bms_core #(
  parameter int WORDS = bms_pkg::WORDS_DEFAULT,
  parameter int AW    = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [bms_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [bms_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  wire logic [bms_pkg::COUNT_W-1:0]     limit,
  output bms_pkg::mem_ctl_t                    mem_ctl,
  output logic      [AW-1:0]                   mem_wr_addr,
  output logic      [bms_pkg::WORD_W-1:0]      mem_wr_data,
  output logic      [AW-1:0]                   mem_rd_addr,
  input  wire logic [bms_pkg::WORD_W-1:0]      mem_rd_data
);

  localparam int W = bms_pkg::WORD_W;
  localparam int C = bms_pkg::COUNT_W;

  bms_pkg::state_t state, state_next;

  logic [AW-1:0]  sweep;
  logic [AW-1:0]  addr;
  bms_pkg::op_t   op;
  logic           oor;
  logic [W-1:0]   mask;
  logic [W-1:0]   data;
  logic [C-1:0]   ones_count;
  logic           out_valid;
  logic [bms_pkg::OUT_TDATA_W-1:0] out_data;

  logic [2:0]     in_op;
  logic [15:0]    in_bit_index;
  logic [9:0]     in_word_index;
  logic [W-1:0]   in_word_data;
  logic [C-1:0]   base;
  logic [C-1:0]   diff;
  logic           in_oor;
  logic [W-1:0]   in_mask;
  logic [AW-1:0]  in_addr;

  logic           accept;
  logic           finish;
  logic           out_free;
  logic           writes;
  logic           gains;
  logic           bit_value;
  logic [W-1:0]   new_word;
  logic [bms_pkg::POP_W-1:0] flips;
  logic [C-1:0]   count_next;

  assign in_op         = s_tdata[2:0];
  assign in_bit_index  = s_tdata[18:3];
  assign in_word_index = s_tdata[28:19];
  assign in_word_data  = s_tdata[92:29];

  assign base = {1'b0, in_word_index, 6'b0};
  assign diff = limit - base;

  always_comb begin
    in_oor  = 1'b0;
    in_mask = '0;
    in_addr = AW'(in_bit_index[15:6]);
    unique case (in_op)
      bms_pkg::OP_SET_BIT, bms_pkg::OP_CLEAR_BIT, bms_pkg::OP_TEST_BIT: begin
        in_oor  = ({1'b0, in_bit_index} >= limit);
        in_mask = W'(1) << in_bit_index[5:0];
      end
      bms_pkg::OP_OR_WORD, bms_pkg::OP_AND_WORD: begin
        in_addr = AW'(in_word_index);
        in_oor  = (limit <= base);
        in_mask = (diff[C-1:6] != '0) ? '1 : ~({W{1'b1}} << diff[5:0]);
      end
      default: begin
      end
    endcase
  end

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == bms_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign finish   = (state == bms_pkg::ST_MODIFY) && out_free;

  always_comb begin
    new_word  = mem_rd_data;
    writes    = 1'b0;
    gains     = 1'b0;
    bit_value = 1'b0;
    unique case (op)
      bms_pkg::OP_SET_BIT: begin
        new_word = mem_rd_data | mask;
        writes   = !oor;
        gains    = 1'b1;
      end
      bms_pkg::OP_CLEAR_BIT: begin
        new_word = mem_rd_data & ~mask;
        writes   = !oor;
      end
      bms_pkg::OP_TEST_BIT: begin
        bit_value = !oor && ((mem_rd_data & mask) != '0);
      end
      bms_pkg::OP_OR_WORD: begin
        new_word = mem_rd_data | (data & mask);
        writes   = !oor;
        gains    = 1'b1;
      end
      bms_pkg::OP_AND_WORD: begin
        new_word = mem_rd_data & (data | ~mask);
        writes   = !oor;
      end
      default: begin
      end
    endcase
  end

  assign flips = bms_pkg::pop64(new_word ^ mem_rd_data);

  always_comb begin
    count_next = ones_count;
    if (op == bms_pkg::OP_CLEAR_ALL) begin
      count_next = '0;
    end else if (writes) begin
      count_next = gains ? ones_count + C'(flips) : ones_count - C'(flips);
    end
  end

  always_comb begin
    state_next = state;
    mem_ctl    = '0;
    unique case (state)
      bms_pkg::ST_CLEAR: begin
        mem_ctl.wr_en = 1'b1;
        if (sweep == AW'(WORDS - 1)) begin
          state_next = bms_pkg::ST_IDLE;
        end
      end
      bms_pkg::ST_IDLE: begin
        mem_ctl.rd_en = accept;
        if (accept) begin
          state_next = bms_pkg::ST_MODIFY;
        end
      end
      bms_pkg::ST_MODIFY: begin
        mem_ctl.wr_en = finish && writes;
        if (finish) begin
          state_next = (op == bms_pkg::OP_CLEAR_ALL) ? bms_pkg::ST_CLEAR : bms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bms_pkg::ST_CLEAR;
      end
    endcase
  end

  assign mem_rd_addr = in_addr;
  assign mem_wr_addr = (state == bms_pkg::ST_CLEAR) ? sweep : addr;
  assign mem_wr_data = (state == bms_pkg::ST_CLEAR) ? '0 : new_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bms_pkg::ST_CLEAR;
      sweep      <= '0;
      ones_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bms_pkg::ST_CLEAR) begin
        sweep <= sweep + AW'(1);
      end else begin
        sweep <= '0;
      end
      if (finish) begin
        ones_count <= count_next;
        out_valid  <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= bms_pkg::op_t'(in_op);
      oor  <= in_oor;
      mask <= in_mask;
      data <= in_word_data;
      addr <= in_addr;
    end
    if (finish) begin
      out_data <= {5'b0, oor, count_next, bit_value};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule
`default_nettype wire

[sv/bitmap_store_with_popcount_top.sv]
// A result word is registered once its input word has been read in the idle state
// and modified in the modify state, which holds while the output is stalled; no new
// input word is taken before the read and the write-back of the single memory word
// each operation touches are done. Clear all and reset each start a sweep over all
// WORDS words (1024 by default) that zeroes the store one word per cycle; no input word is taken during the sweep.
// Reset is synchronous and active high; the configuration port answers throughout.
`default_nettype none
`include "bitmap_store_with_popcount_top_macros.svh"
module bitmap_store_with_popcount_top #(
  parameter int WORDS = bms_pkg::WORDS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // tdata: opcode[2:0], bit_index[18:3], word_index[28:19], word_data[92:29], zeros
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [bms_pkg::IN_TDATA_W-1:0]   s_tdata,
  // tdata: bit_value[0], set_count[17:1], out_of_range[18], zeros
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic      [bms_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [bms_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [bms_pkg::PDATA_W-1:0]      pwdata,
  output logic      [bms_pkg::PDATA_W-1:0]      prdata,
  output logic                                  pready
);

  localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [bms_pkg::COUNT_W-1:0] limit;
  bms_pkg::mem_ctl_t           mem_ctl;
  logic [AW-1:0]               mem_wr_addr;
  logic [AW-1:0]               mem_rd_addr;
  logic [bms_pkg::WORD_W-1:0]  mem_wr_data;
  logic [bms_pkg::WORD_W-1:0]  mem_rd_data;

  bms_regs #(.WORDS(WORDS)) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit   (limit)
  );

  bms_mem #(.WORDS(WORDS), .AW(AW)) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  bms_core #(.WORDS(WORDS), .AW(AW)) u_core (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .limit       (limit),
    .mem_ctl     (mem_ctl),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  `BMS_ASSERT_NOW(a_no_read_during_write, mem_ctl.wr_en, !mem_ctl.rd_en, "Memory read and write collide.")
  `BMS_ASSERT_NEXT(a_one_word_in_flight, s_tvalid && s_tready, !s_tready, "A second word was taken while one is in flight.")
  `BMS_ASSERT_NOW(a_count_bounded, m_tvalid, m_tdata[17:1] <= limit || m_tdata[17:1] <= 17'h10000, "Set-bit count exceeds the store size.")
  `BMS_ASSERT_NOW(a_flag_excludes_bit, m_tvalid && m_tdata[18], !m_tdata[0], "A rejected word reports a set bit.")

endmodule
`default_nettype wire
